// ----- rtl/fae_pkg.sv -----
package fae_pkg;

  // default frame dimension limit
  localparam int unsigned MAX_DIMENSION_DEF = 2048;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LARGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MEDIUM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SMALL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned DIM_IN_W = 12;
  localparam int unsigned EXP_W  = 32;

  // reset values
  localparam logic [PIX_W-1:0]    TARGET_LEVEL_RST = 8'd61;
  localparam logic [STEP_W-1:0]   STEP_LARGE_RST   = 16'd1000;
  localparam logic [STEP_W-1:0]   STEP_MEDIUM_RST  = 16'd500;
  localparam logic [STEP_W-1:0]   STEP_SMALL_RST   = 16'd200;
  localparam logic [DIM_IN_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_IN_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [EXP_W-1:0]    EXPOSURE_RST     = 32'd11264;

  // distance thresholds for the step rule
  localparam logic [PIX_W-1:0] DIST_LARGE  = 8'd64;
  localparam logic [PIX_W-1:0] DIST_MEDIUM = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DIFF_A,
    ST_DIFF_B,
    ST_EXP
  } fae_state_e;

endpackage

// ----- rtl/fae_alu.sv -----
module fae_alu #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         carry_o
);

  logic [W-1:0] b_eff;

  // subtract as a + ~b + 1, carry set means no borrow
  assign b_eff = sub_i ? ~b_i : b_i;
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, sub_i};

endmodule

// ----- rtl/frame_auto_exposure_stepper.sv -----
// channel  | dir | handshake                   | payload
// ---------+-----+-----------------------------+--------------------------------
// pixel    | in  | in_valid_i / in_stall_o     | pixel_i[7:0]
// result   | out | out_valid_o / out_stall_i   | mean_level_o[7:0], exposure_o[31:0]
// config   | in  | cfg_we_i (no wait)          | cfg_idx_i[2:0], cfg_data_i[15:0]
//
// a pixel that does not close the frame passes the accept and size check steps
// a frame-closing pixel then goes on through eight restoring division steps,
//   one or two distance steps and the exposure step, all on the one shared
//   add/subtract unit
// the exposure step waits while the previous result beat is still stalled
// reset is asynchronous active low and restores the register defaults
module frame_auto_exposure_stepper #(
  parameter int unsigned MAX_DIMENSION = fae_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fae_pkg::PIX_W-1:0]           pixel_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fae_pkg::PIX_W-1:0]           mean_level_o,
  output logic [fae_pkg::EXP_W-1:0]           exposure_o,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [fae_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fae_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import fae_pkg::*;

  // clamped dimension, pixel count, pixel sum and shared unit widths
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
  localparam int unsigned SUM_W = CNT_W + PIX_W;
  localparam int unsigned ALU_W = (SUM_W > EXP_W) ? SUM_W : EXP_W;

  // dimension of zero counts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_IN_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIMENSION) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  // configuration registers
  logic [PIX_W-1:0]    target_q;
  logic [STEP_W-1:0]   step_large_q, step_medium_q, step_small_q;
  logic [DIM_IN_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= TARGET_LEVEL_RST;
      step_large_q  <= STEP_LARGE_RST;
      step_medium_q <= STEP_MEDIUM_RST;
      step_small_q  <= STEP_SMALL_RST;
      width_q       <= FRAME_WIDTH_RST;
      height_q      <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_LEVEL: target_q      <= cfg_data_i[PIX_W-1:0];
        REG_STEP_LARGE:   step_large_q  <= cfg_data_i[STEP_W-1:0];
        REG_STEP_MEDIUM:  step_medium_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_SMALL:   step_small_q  <= cfg_data_i[STEP_W-1:0];
        REG_FRAME_WIDTH:  width_q       <= cfg_data_i[DIM_IN_W-1:0];
        REG_FRAME_HEIGHT: height_q      <= cfg_data_i[DIM_IN_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // frame size, registered after the multiplier; settles in the cycle after a
  // register write, before any pixel accepted after it reaches the size check
  logic [CNT_W-1:0] frame_size_q;

  always_ff @(posedge clk_i) begin
    frame_size_q <= CNT_W'(clamp_dim(width_q) * clamp_dim(height_q));
  end

  // sequencer and datapath state
  fae_state_e        state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ALU_W-1:0]  rem_q, rem_d;
  logic [2:0]        bit_q, bit_d;
  logic [PIX_W-1:0]  quot_q, quot_d;
  logic [PIX_W-1:0]  dist_q, dist_d;
  logic              down_q, down_d;
  logic [EXP_W-1:0]  exposure_q, exposure_d;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  mean_out_q, mean_out_d;
  logic [EXP_W-1:0]  exp_out_q, exp_out_d;

  // shared add/subtract unit
  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;

  fae_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // step picked from the distance to the target
  logic [STEP_W-1:0] step_sel;

  always_comb begin
    if (dist_q >= DIST_LARGE) begin
      step_sel = step_large_q;
    end else if (dist_q >= DIST_MEDIUM) begin
      step_sel = step_medium_q;
    end else if (dist_q != '0) begin
      step_sel = step_small_q;
    end else begin
      step_sel = '0;
    end
  end

  logic in_accept;
  logic out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // result register can take a new beat this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    quot_d      = quot_q;
    dist_d      = dist_q;
    down_d      = down_q;
    exposure_d  = exposure_q;
    mean_out_d  = mean_out_q;
    exp_out_d   = exp_out_q;
    out_valid_d = out_valid_q && out_stall_i;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sum_d   = sum_q + SUM_W'(pixel_i);
          count_d = count_q + CNT_W'(1);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (count_q >= frame_size_q) begin
          // frame closed: start the division with the whole sum as remainder
          rem_d   = ALU_W'(sum_q);
          sum_d   = '0;
          bit_d   = 3'd7;
          quot_d  = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // restoring step: try to take count << bit from the remainder
        alu_a = rem_q;
        alu_b = ALU_W'(count_q) << bit_q;
        if (alu_carry) begin
          rem_d         = alu_res;
          quot_d[bit_q] = 1'b1;
        end
        if (bit_q == 3'd0) begin
          count_d = '0;
          state_d = ST_DIFF_A;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      ST_DIFF_A: begin
        // mean minus target; no borrow means exposure goes down
        alu_a = ALU_W'(quot_q);
        alu_b = ALU_W'(target_q);
        if (alu_carry) begin
          dist_d  = alu_res[PIX_W-1:0];
          down_d  = 1'b1;
          state_d = ST_EXP;
        end else begin
          state_d = ST_DIFF_B;
        end
      end
      ST_DIFF_B: begin
        alu_a   = ALU_W'(target_q);
        alu_b   = ALU_W'(quot_q);
        dist_d  = alu_res[PIX_W-1:0];
        down_d  = 1'b0;
        state_d = ST_EXP;
      end
      ST_EXP: begin
        alu_a   = ALU_W'(exposure_q);
        alu_b   = ALU_W'(step_sel);
        alu_sub = down_q;
        if (out_free) begin
          // wraps modulo 2^32
          exposure_d  = alu_res[EXP_W-1:0];
          mean_out_d  = quot_q;
          exp_out_d   = alu_res[EXP_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      exposure_q  <= EXPOSURE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      exposure_q  <= exposure_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    quot_q     <= quot_d;
    dist_q     <= dist_d;
    down_q     <= down_d;
    mean_out_q <= mean_out_d;
    exp_out_q  <= exp_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign mean_level_o = mean_out_q;
  assign exposure_o   = exp_out_q;

  // every accepted pixel goes through the size check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_CHECK)
    else $error("accepted pixel not followed by size check");

  // divisor is never zero during division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> count_q != '0)
    else $error("division with zero pixel count");

  // remainder stays below divisor shifted one past the current bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |->
      ({1'b0, rem_q} < ((ALU_W + 1)'(count_q) << (4'(bit_q) + 4'd1))))
    else $error("division remainder out of range");

  // a new result beat only comes out of the exposure step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q) == ST_EXP)
    else $error("result beat without exposure step");

endmodule

// ----- sim/tb_frame_auto_exposure_stepper.sv -----
module tb_frame_auto_exposure_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  import fae_pkg::*;

  // cycles a frame-closing pixel may still be in flight after its last
  // beat: size check, division, distance and exposure steps, plus margin
  localparam int unsigned SETTLE_CYCLES = 16;
  // the whole run, slowest legal case taken several times over
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // pixel beats in the randomized part
  localparam int unsigned RANDOM_PIXELS = 1500;
  // pixels sent into a frame at the dimension limit before it is cut short
  localparam int unsigned PARTIAL_PIXELS = 64;
  // printed mismatch lines before going quiet
  localparam int unsigned PRINT_CAP = 40;

  // register indexes past the end of the map, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  // one result beat: mean brightness and the exposure after the step rule
  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic [EXP_W-1:0] exposure;
  } frame_update_t;

  // directed script: a register write or a pixel beat
  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      pix;
    logic                  typed;     // result typed in below, else predicted
    logic [PIX_W-1:0]      mean;
    logic [EXP_W-1:0]      exposure;
  } script_row_t;

  // brightness patterns for a random frame
  typedef enum logic [1:0] {
    PAT_NOISE,
    PAT_FLAT,
    PAT_NEAR_TARGET,
    PAT_BLACK_WHITE
  } pattern_e;

  localparam int unsigned N_ROWS = 37;

  // every input driven to a known value from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      mean_level_o;
  logic [EXP_W-1:0]      exposure_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // shadow copy of the registers, at their reset values
  logic [PIX_W-1:0]    shadow_target      = TARGET_LEVEL_RST;
  logic [STEP_W-1:0]   shadow_step_large  = STEP_LARGE_RST;
  logic [STEP_W-1:0]   shadow_step_medium = STEP_MEDIUM_RST;
  logic [STEP_W-1:0]   shadow_step_small  = STEP_SMALL_RST;
  logic [DIM_IN_W-1:0] shadow_width       = FRAME_WIDTH_RST;
  logic [DIM_IN_W-1:0] shadow_height      = FRAME_HEIGHT_RST;

  // shadow frame accumulator and exposure
  logic [31:0]      frame_sum     = '0;
  int unsigned      frame_seen    = 0;
  logic [EXP_W-1:0] exposure_now  = EXPOSURE_RST;

  frame_update_t pending_updates[$];

  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_left   = 0;
  bit          rx_stalling  = 1'b0;

  // directed part: rule bands on both sides of the target, wrap both ways,
  // register extremes, masked data bits, dropped indexes, zero dimensions
  // and a frame shrunk under the pixels already taken
  script_row_t script [N_ROWS] = '{
    // one-pixel frames; upper data bits of the width write are dropped
    '{ROW_CFG, REG_FRAME_WIDTH,  16'hF001, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'h0001, '0, 1'b0, '0, '0},
    // target 61: large, medium and small steps down and up, and no step
    '{ROW_PIX, '0, '0, 8'd255, 1'b1, 8'd255, 32'd10264},
    '{ROW_PIX, '0, '0, 8'd0,   1'b1, 8'd0,   32'd10764},
    '{ROW_PIX, '0, '0, 8'd61,  1'b1, 8'd61,  32'd10764},
    '{ROW_PIX, '0, '0, 8'd40,  1'b1, 8'd40,  32'd10964},
    '{ROW_PIX, '0, '0, 8'd93,  1'b1, 8'd93,  32'd10464},
    '{ROW_PIX, '0, '0, 8'd92,  1'b1, 8'd92,  32'd10264},
    '{ROW_PIX, '0, '0, 8'd125, 1'b1, 8'd125, 32'd9264},
    '{ROW_PIX, '0, '0, 8'd124, 1'b1, 8'd124, 32'd8764},
    '{ROW_PIX, '0, '0, 8'd62,  1'b1, 8'd62,  32'd8564},
    '{ROW_PIX, '0, '0, 8'd60,  1'b1, 8'd60,  32'd8764},
    // target 0 and the largest step: exposure wraps below zero
    '{ROW_CFG, REG_TARGET_LEVEL, 16'h0000, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_STEP_LARGE,   16'hFFFF, '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd255, 1'b1, 8'd255, 32'd4294910525},
    '{ROW_PIX, '0, '0, 8'd0,   1'b1, 8'd0,   32'd4294910525},
    // target 255 through masked upper bits: wraps back up
    '{ROW_CFG, REG_TARGET_LEVEL, 16'hABFF, '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd0,   1'b1, 8'd0,   32'd8764},
    // writes past the register map change nothing
    '{ROW_CFG, REG_UNUSED_6,     16'h0003, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_UNUSED_7,     16'h0003, '0, 1'b0, '0, '0},
    // zero dimensions act as one
    '{ROW_CFG, REG_FRAME_WIDTH,  16'h0000, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'h0000, '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd255, 1'b1, 8'd255, 32'd8764},
    '{ROW_CFG, REG_STEP_LARGE,   16'h0000, '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd0,   1'b1, 8'd0,   32'd8764},
    // medium step at its top, small step at zero
    '{ROW_CFG, REG_STEP_MEDIUM,  16'hFFFF, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_STEP_SMALL,   16'h0000, '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_TARGET_LEVEL, 16'd100,  '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd60,  1'b1, 8'd60,  32'd74299},
    '{ROW_PIX, '0, '0, 8'd99,  1'b1, 8'd99,  32'd74299},
    // four-pixel frame shrunk to two after three pixels
    '{ROW_CFG, REG_STEP_SMALL,   16'd7,    '0, 1'b0, '0, '0},
    '{ROW_CFG, REG_FRAME_WIDTH,  16'd4,    '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd10,  1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd20,  1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd30,  1'b0, '0, '0},
    '{ROW_CFG, REG_FRAME_WIDTH,  16'd2,    '0, 1'b0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd41,  1'b0, '0, '0}
  };

  frame_auto_exposure_stepper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_level_o(mean_level_o),
    .exposure_o  (exposure_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // zero counts as one, anything past the limit saturates
  function automatic int unsigned effective_dim(input logic [DIM_IN_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return int'(d);
  endfunction

  // fold one pixel into the shadow frame; returns 1 with the update when
  // this pixel closes the frame under the size in force right now
  function automatic bit integrate_pixel(input logic [PIX_W-1:0] pix,
                                         output frame_update_t upd);
    logic [PIX_W-1:0]  mean;
    logic [PIX_W-1:0]  distance;
    logic [STEP_W-1:0] step;
    frame_sum  = frame_sum + pix;
    frame_seen = frame_seen + 1;
    upd = '0;
    if (frame_seen < effective_dim(shadow_width) * effective_dim(shadow_height))
      return 1'b0;
    mean = PIX_W'(frame_sum / frame_seen);
    distance = (mean > shadow_target) ? mean - shadow_target : shadow_target - mean;
    if (distance >= DIST_LARGE) begin
      step = shadow_step_large;
    end else if (distance >= DIST_MEDIUM) begin
      step = shadow_step_medium;
    end else if (distance != '0) begin
      step = shadow_step_small;
    end else begin
      step = '0;
    end
    // bright frame closes the shutter, dark frame opens it, 32-bit wrap
    if (mean > shadow_target) begin
      exposure_now = exposure_now - EXP_W'(step);
    end else begin
      exposure_now = exposure_now + EXP_W'(step);
    end
    frame_sum    = '0;
    frame_seen   = 0;
    upd.mean     = mean;
    upd.exposure = exposure_now;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  // one register write; the block is idle whenever this is called
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TARGET_LEVEL: shadow_target      = data[PIX_W-1:0];
      REG_STEP_LARGE:   shadow_step_large  = data[STEP_W-1:0];
      REG_STEP_MEDIUM:  shadow_step_medium = data[STEP_W-1:0];
      REG_STEP_SMALL:   shadow_step_small  = data[STEP_W-1:0];
      REG_FRAME_WIDTH:  shadow_width       = data[DIM_IN_W-1:0];
      REG_FRAME_HEIGHT: shadow_height      = data[DIM_IN_W-1:0];
      default: ;
    endcase
  endtask

  // one pixel beat, in bursts of random length with random gaps between;
  // valid stays up across back-to-back beats
  task automatic send_pixel(input logic [PIX_W-1:0] pix, output bit closed);
    int unsigned   gap;
    frame_update_t upd;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // every third stretch of the cycle count runs without gaps
      gap = ((cycle_count / 1500) % 3 == 2) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    burst_left--;
    // beat taken at the first edge with stall low
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    closed = integrate_pixel(pix, upd);
    if (closed)
      pending_updates.push_back(upd);
  endtask

  // hold off until every frame update has come back and the block has
  // settled, so a register write lands on an idle block
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // small frame sizes, garbage in the upper data bits
  task automatic resize_frame();
    logic [DIM_IN_W-1:0] w;
    logic [DIM_IN_W-1:0] h;
    if ($urandom_range(0, 9) == 0) begin
      w = DIM_IN_W'($urandom_range(7, 40));
      h = DIM_IN_W'(1);
    end else begin
      w = DIM_IN_W'($urandom_range(0, 6));
      h = DIM_IN_W'($urandom_range(0, 4));
    end
    write_reg(REG_FRAME_WIDTH,  {4'($urandom), w});
    write_reg(REG_FRAME_HEIGHT, {4'($urandom), h});
  endtask

  // target and steps, each picked or left alone, extremes favored
  task automatic retune_settings();
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0]  idx;
    if ($urandom_range(0, 1) == 1) begin
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 3))
        0: data[PIX_W-1:0] = '0;
        1: data[PIX_W-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_TARGET_LEVEL, data);
    end
    for (int s = 0; s < 3; s++) begin
      if ($urandom_range(0, 1) == 1) begin
        idx = (s == 0) ? REG_STEP_LARGE : (s == 1) ? REG_STEP_MEDIUM : REG_STEP_SMALL;
        case ($urandom_range(0, 4))
          0: data = '0;
          1: data = '1;
          2: data = CFG_DATA_W'($urandom_range(1, 255));
          default: data = CFG_DATA_W'($urandom);
        endcase
        write_reg(idx, data);
      end
    end
    if ($urandom_range(0, 7) == 0)
      write_reg(($urandom_range(0, 1) == 1) ? REG_UNUSED_6 : REG_UNUSED_7,
                CFG_DATA_W'($urandom));
  endtask

  // pixels until the shadow says the frame closed; sometimes the size is
  // rewritten partway through, which may close the frame early
  task automatic send_frame(input bit allow_resize, output int unsigned sent);
    pattern_e         pattern;
    int               level;
    int unsigned      resize_at;
    bit               closed;
    logic [PIX_W-1:0] pix;
    pattern = pattern_e'($urandom_range(0, 3));
    if (pattern == PAT_NEAR_TARGET) begin
      // land on the band edges around the target
      case ($urandom_range(0, 10))
        0: level = int'(shadow_target) - 64;
        1: level = int'(shadow_target) - 63;
        2: level = int'(shadow_target) - 32;
        3: level = int'(shadow_target) - 31;
        4: level = int'(shadow_target) - 1;
        5: level = int'(shadow_target);
        6: level = int'(shadow_target) + 1;
        7: level = int'(shadow_target) + 31;
        8: level = int'(shadow_target) + 32;
        9: level = int'(shadow_target) + 63;
        default: level = int'(shadow_target) + 64;
      endcase
      if (level < 0) level = 0;
      if (level > 255) level = 255;
    end else begin
      level = int'($urandom_range(0, 255));
    end
    resize_at = (allow_resize && $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
    sent   = 0;
    closed = 1'b0;
    while (!closed) begin
      if (resize_at != 0 && sent == resize_at) begin
        wait_idle();
        resize_frame();
      end
      case (pattern)
        PAT_NOISE:       pix = PIX_W'($urandom);
        PAT_BLACK_WHITE: pix = ($urandom_range(0, 1) == 1) ? '1 : '0;
        default:         pix = PIX_W'(level);
      endcase
      send_pixel(pix, closed);
      sent++;
    end
  endtask

  // receiver: random stall runs, with a quiet stretch in every fourth
  // stretch of the cycle count
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if ((cycle_count / 1000) % 4 == 1) begin
      out_stall_i <= 1'b0;
      stall_left = 64;
    end else begin
      rx_stalling = ($urandom_range(0, 2) == 0);
      out_stall_i <= rx_stalling;
      stall_left = rx_stalling ? $urandom_range(0, 11) : $urandom_range(0, 19);
    end
  end

  // result beats against the oldest frame update, plus the run limit
  always @(posedge clk_i) begin : result_check
    frame_update_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("result beat with no frame pending", exposure_o, '0);
      end else begin
        want = pending_updates.pop_front();
        if (mean_level_o !== want.mean)
          report_mismatch("mean_level", mean_level_o, want.mean);
        if (exposure_o !== want.exposure)
          report_mismatch("exposure", exposure_o, want.exposure);
      end
    end
  end

  initial begin
    bit          closed;
    int unsigned sent;
    int unsigned phase;
    int unsigned random_pixels;
    phase         = 0;
    random_pixels = 0;

    // reset held low from time zero, released once
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed script
    for (int r = 0; r < N_ROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_pixel(script[r].pix, closed);
        if (script[r].typed) begin
          if (!closed) begin
            report_mismatch("frame end missing in shadow", 0, 1);
          end else begin
            pending_updates[pending_updates.size() - 1] =
              '{mean: script[r].mean, exposure: script[r].exposure};
          end
        end
      end
    end

    // randomized phases: retune while idle, then a few small frames;
    // two phases first start a frame at the dimension limit and cut it
    // short with the resize that follows
    while (random_pixels < RANDOM_PIXELS) begin
      wait_idle();
      retune_settings();
      if (phase == 3 || phase == 6) begin
        // width saturating from 4095, then a column at the height limit
        write_reg(REG_FRAME_WIDTH,  (phase == 3) ? 16'h0FFF : 16'h0000);
        write_reg(REG_FRAME_HEIGHT, (phase == 3) ? 16'h0001 : 16'd2048);
        repeat (PARTIAL_PIXELS) begin
          send_pixel(PIX_W'($urandom), closed);
        end
        random_pixels += PARTIAL_PIXELS;
        wait_idle();
      end
      resize_frame();
      repeat ($urandom_range(1, 6)) begin
        send_frame(1'b1, sent);
        random_pixels += sent;
      end
      phase++;
    end

    // drain and let any stray beat show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fae_pkg.sv
rtl/fae_alu.sv
rtl/frame_auto_exposure_stepper.sv
sim/tb_frame_auto_exposure_stepper.sv
